/* rtl/core/sample_stream_edge_extractor_core_assert.svh */
// Assertion macros shared by the edge extractor core modules.
// No dependencies; included by the modules that carry assertions.
`ifndef SAMPLE_STREAM_EDGE_EXTRACTOR_CORE_ASSERT_SVH
`define SAMPLE_STREAM_EDGE_EXTRACTOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define SSEE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ssee assertion failed");

// Next-cycle implication, disabled while in reset.
`define SSEE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ssee assertion failed");

`endif

/* rtl/core/ssee_pkg.sv */
// Shared types and constants for the sample stream edge extractor core.
// No dependencies; used by every module of the core.
package ssee_pkg;

  localparam int LANES          = 8;
  localparam int NUM_EV         = LANES + 2;
  localparam int EV_FIN_START   = LANES;
  localparam int EV_DONE        = LANES + 1;
  localparam int INDEX_BITS_DEF = 32;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_ID   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_START = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_END   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VALID_COUNT  = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_EDGE  = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;

  typedef struct packed {
    logic [7:0] sample_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  channel;
    logic [1:0]  kind;
    logic [31:0] at_sample;
    logic        level;
    logic        last_of_item;
  } out_item_t;

  // per-lane window compare results
  typedef struct packed {
    logic at_start;
    logic after_start;
    logic before_end;
    logic lvl;
  } lane_flags_t;

  // everything the serializer needs to replay one byte's results
  typedef struct packed {
    logic [NUM_EV-1:0] mask;
    logic [LANES-1:0]  start_oh;
    logic [LANES-1:0]  bits;
    logic [31:0]       byte_pos;
    logic [31:0]       win_start;
    logic [3:0]        channel;
  } item_events_t;

endpackage

/* rtl/core/sample_stream_edge_extractor_core.sv */
// Top level of the sample stream edge extractor core.
// Depends on ssee_pkg, ssee_lane, ssee_merge and ssee_serializer.
//
//   channel | handshake             | payload
//   --------+-----------------------+-----------------------------------------
//   in      | in_valid / in_stall   | in_data  : sample_byte, final_byte
//   out     | out_valid / out_stall | out_data : channel, kind, at_sample, ...
//   cfg     | cfg_we                | cfg_index, cfg_wdata (write only)
//
// A byte is examined by eight sample lanes in the cycle of its transfer; the
// merge stage orders their events and the scan state is updated at once.
// Results then leave one per transfer from the serializer's output register;
// a byte's events wait in the serializer's mask register before each result
// is registered there, so a byte with n results takes n result transfers (0 to 9);
// the serializer takes the next byte in the cycle its last result moves on.
// Bytes without results pass at one per cycle while no results are queued.
// rst_n is synchronous, active low; it clears registers and scan state.
// out_stall holds the output register; in_stall rises only while a byte's
// results are still queued.
module sample_stream_edge_extractor_core #(
  parameter int INDEX_BITS = ssee_pkg::INDEX_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  ssee_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output ssee_pkg::out_item_t             out_data,
  input  logic                            cfg_we,
  input  logic [ssee_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ssee_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import ssee_pkg::*;

  // configuration registers
  logic [3:0]  chan_id_r;
  logic [31:0] win_start_r;
  logic [31:0] win_end_r;
  logic [31:0] valid_cnt_r;

  // scan state
  logic [31:0] byte_pos_r, byte_pos_nxt;
  logic        level_r, level_nxt;
  logic        started_r, started_nxt;
  logic        finished_r, finished_nxt;

  logic                         in_xfer;
  logic                         ser_busy;
  logic [31:0]                  eff_end;
  logic                         active;
  lane_flags_t [LANES-1:0]      flags;
  logic [NUM_EV-1:0]            ev_mask;
  logic [LANES-1:0]             start_oh;
  logic                         mrg_started;
  logic                         mrg_level;
  item_events_t                 ev;

  assign in_stall = ser_busy;
  assign in_xfer  = in_valid && !in_stall;

  // window end of 0, or past the valid count, falls back to the valid count
  assign eff_end = ((win_end_r == '0) || (win_end_r > valid_cnt_r)) ? valid_cnt_r : win_end_r;
  assign active  = (win_start_r < valid_cnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_id_r   <= '0;
      win_start_r <= '0;
      win_end_r   <= '0;
      valid_cnt_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CHANNEL_ID:   chan_id_r   <= cfg_wdata[3:0];
        REG_WINDOW_START: win_start_r <= cfg_wdata;
        REG_WINDOW_END:   win_end_r   <= cfg_wdata;
        REG_VALID_COUNT:  valid_cnt_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // one lane per sample bit
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    ssee_lane #(
      .LANE (g)
    ) u_lane (
      .byte_pos  (byte_pos_r),
      .sample    (in_data.sample_byte[g]),
      .win_start (win_start_r),
      .win_end   (eff_end),
      .flags     (flags[g])
    );
  end

  ssee_merge u_merge (
    .flags       (flags),
    .active      (active),
    .final_byte  (in_data.final_byte),
    .started     (started_r),
    .level       (level_r),
    .ev_mask     (ev_mask),
    .start_oh    (start_oh),
    .started_nxt (mrg_started),
    .level_nxt   (mrg_level)
  );

  // once the final byte has gone by, later bytes produce nothing
  always_comb begin
    ev           = '0;
    ev.mask      = finished_r ? '0 : ev_mask;
    ev.start_oh  = start_oh;
    ev.bits      = in_data.sample_byte;
    ev.byte_pos  = byte_pos_r;
    ev.win_start = win_start_r;
    ev.channel   = chan_id_r;
  end

  always_comb begin
    byte_pos_nxt = byte_pos_r;
    level_nxt    = level_r;
    started_nxt  = started_r;
    finished_nxt = finished_r;
    if (in_xfer && !finished_r) begin
      level_nxt    = mrg_level;
      started_nxt  = mrg_started;
      finished_nxt = in_data.final_byte;
      if (byte_pos_r != '1) begin
        byte_pos_nxt = byte_pos_r + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_pos_r <= '0;
      level_r    <= 1'b0;
      started_r  <= 1'b0;
      finished_r <= 1'b0;
    end else begin
      byte_pos_r <= byte_pos_nxt;
      level_r    <= level_nxt;
      started_r  <= started_nxt;
      finished_r <= finished_nxt;
    end
  end

  ssee_serializer #(
    .INDEX_BITS (INDEX_BITS)
  ) u_serializer (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_xfer),
    .ev        (ev),
    .busy      (ser_busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

/* rtl/core/ssee_lane.sv */
// One sample lane: places its sample against the scan window.
// Depends on ssee_pkg.
module ssee_lane #(
  parameter int LANE = 0
) (
  input  logic [31:0]           byte_pos,
  input  logic                  sample,
  input  logic [31:0]           win_start,
  input  logic [31:0]           win_end,
  output ssee_pkg::lane_flags_t flags
);
  import ssee_pkg::*;

  logic [34:0] idx;
  logic [34:0] s_ext;
  logic [34:0] e_ext;

  assign idx   = {byte_pos, 3'(LANE)};
  assign s_ext = {3'b000, win_start};
  assign e_ext = {3'b000, win_end};

  assign flags.at_start    = (idx == s_ext);
  assign flags.after_start = (idx > s_ext);
  assign flags.before_end  = (idx < e_ext);
  assign flags.lvl         = sample;

endmodule

/* rtl/core/ssee_merge.sv */
// Merge stage: walks the lane flags in sample order, finds start and edge
// events and the scan state left for the next byte. Depends on ssee_pkg.
module ssee_merge (
  input  ssee_pkg::lane_flags_t [ssee_pkg::LANES-1:0] flags,
  input  logic                                        active,
  input  logic                                        final_byte,
  input  logic                                        started,
  input  logic                                        level,
  output logic [ssee_pkg::NUM_EV-1:0]                 ev_mask,
  output logic [ssee_pkg::LANES-1:0]                  start_oh,
  output logic                                        started_nxt,
  output logic                                        level_nxt
);
  import ssee_pkg::*;

  logic sr;
  logic lv;
  logic in_win;

  always_comb begin
    sr       = started;
    lv       = level;
    ev_mask  = '0;
    start_oh = '0;
    in_win   = 1'b0;
    for (int b = 0; b < LANES; b++) begin
      in_win = active && sr && flags[b].after_start && flags[b].before_end;
      start_oh[b] = active && !sr && flags[b].at_start;
      ev_mask[b]  = start_oh[b] || (in_win && (flags[b].lvl != lv));
      if (start_oh[b] || in_win) begin
        lv = flags[b].lvl;
      end
      if (start_oh[b]) begin
        sr = 1'b1;
      end
    end
    // buffer ended before the start sample: level reads as 0
    if (final_byte && active && !sr) begin
      ev_mask[EV_FIN_START] = 1'b1;
      sr = 1'b1;
      lv = 1'b0;
    end
    ev_mask[EV_DONE] = final_byte;
    started_nxt = sr;
    level_nxt   = lv;
  end

endmodule

/* rtl/core/ssee_serializer.sv */
// Result serializer: holds one byte's event set and sends one result per
// transfer through an output register. Depends on ssee_pkg and the macros.
module ssee_serializer #(
  parameter int INDEX_BITS = ssee_pkg::INDEX_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load,
  input  ssee_pkg::item_events_t ev,
  output logic                   busy,
  output logic                   out_valid,
  input  logic                   out_stall,
  output ssee_pkg::out_item_t    out_data
);
  import ssee_pkg::*;
  `include "sample_stream_edge_extractor_core_assert.svh"

  localparam int AT_W = (INDEX_BITS < 32) ? INDEX_BITS : 32;

  logic [NUM_EV-1:0] mask_r, mask_nxt;
  logic [LANES-1:0]  start_oh_r;
  logic [LANES-1:0]  bits_r;
  logic [AT_W-4:0]   base_hi_r;
  logic [AT_W-1:0]   s_r;
  logic [3:0]        chan_r;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, res;
  logic [NUM_EV-1:0] pick;
  logic [NUM_EV-1:0] rest;
  logic              advance;

  assign pick    = mask_r & (~mask_r + {{(NUM_EV-1){1'b0}}, 1'b1});
  assign rest    = mask_r & ~pick;
  assign advance = (|mask_r) && (!out_valid_r || !out_stall);
  assign busy    = (|mask_r) && !(advance && (rest == '0));

  always_comb begin
    res              = '0;
    res.channel      = chan_r;
    res.last_of_item = (rest == '0);
    res.kind         = KIND_DONE;
    for (int b = 0; b < LANES; b++) begin
      if (pick[b]) begin
        res.kind                = start_oh_r[b] ? KIND_START : KIND_EDGE;
        res.at_sample[AT_W-1:0] = {base_hi_r, 3'(b)};
        res.level               = bits_r[b];
      end
    end
    if (pick[EV_FIN_START]) begin
      res.kind                = KIND_START;
      res.at_sample[AT_W-1:0] = s_r;
    end
  end

  always_comb begin
    mask_nxt = mask_r;
    if (advance) begin
      mask_nxt = rest;
    end
    if (load) begin
      mask_nxt = ev.mask;
    end
    out_valid_nxt = out_valid_r && out_stall;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mask_r      <= mask_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      start_oh_r <= ev.start_oh;
      bits_r     <= ev.bits;
      base_hi_r  <= ev.byte_pos[AT_W-4:0];
      s_r        <= ev.win_start[AT_W-1:0];
      chan_r     <= ev.channel;
    end
    if (advance) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `SSEE_ASSERT_IMPL(a_done_is_last, clk, rst_n,
    out_valid_r && (out_data_r.kind == KIND_DONE), out_data_r.last_of_item)
  `SSEE_ASSERT_NEXT(a_load_holds_events, clk, rst_n,
    load && (ev.mask != '0), (mask_r != '0))
  `SSEE_ASSERT_IMPL(a_no_load_over_pending, clk, rst_n,
    load, !busy)

endmodule

/* dv/tb_sample_stream_edge_extractor_core.sv */
`timescale 1ns / 100ps
// Self-checking bench for sample_stream_edge_extractor_core: scan bytes in, edge results out.
// Depends on ssee_pkg and the core RTL; a built-in predictor checks every result transfer.

module tb_sample_stream_edge_extractor_core;
  import ssee_pkg::*;

  localparam int QUIET_CYCLES = 24;   // pause before a register write and at the end
  localparam int IDLE_LIMIT   = 4000; // cycles without any transfer before giving up
  localparam int RANDOM_ITEMS = 215;
  localparam int REPORT_LIMIT = 10;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  sample_stream_edge_extractor_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Register copies and scan state of the predictor
  logic [3:0]  chan_label  = '0;
  logic [31:0] win_first   = '0;
  logic [31:0] win_limit   = '0;
  logic [31:0] stored_len  = '0;
  logic [31:0] scan_pos    = '0;
  logic        scan_level  = 1'b0;
  logic        start_seen  = 1'b0;
  logic        scan_closed = 1'b0;

  in_item_t  pending_bytes[$];
  out_item_t expected_events[$];

  int   sender_idle_pct = 0;
  int   recv_stall_pct  = 0;
  logic in_taken        = 1'b0;
  int   fail_count      = 0;
  int   idle_cycles     = 0;

  function automatic out_item_t make_event(input logic [1:0] kind, input logic [31:0] at,
                                           input logic lvl);
    out_item_t ev;
    ev.channel      = chan_label;
    ev.kind         = kind;
    ev.at_sample    = at;
    ev.level        = lvl;
    ev.last_of_item = 1'b0;
    return ev;
  endfunction

  // Works out the events one scanned byte produces and queues them in order.
  function automatic void extract_byte_events(input in_item_t item);
    out_item_t   batch[NUM_EV];
    int          n;
    logic [63:0] first_w, len_w, stop_w, base, j;
    logic        active, lvl;
    n = 0;
    if (scan_closed)
      return;
    first_w = win_first;
    len_w   = stored_len;
    // a zero end, or one past the stored length, means the stored length
    stop_w  = (win_limit == 0 || win_limit > stored_len) ? len_w : {32'd0, win_limit};
    active  = first_w < len_w;
    base    = {32'd0, scan_pos} << 3;
    if (active) begin
      for (int b = 0; b < 8; b++) begin
        j   = base + 64'(b);
        lvl = item.sample_byte[b];
        if (!start_seen) begin
          if (j == first_w) begin
            batch[n]   = make_event(KIND_START, j[31:0], lvl);
            n++;
            scan_level = lvl;
            start_seen = 1'b1;
          end
        end else if (j > first_w && j < stop_w && lvl != scan_level) begin
          batch[n]   = make_event(KIND_EDGE, j[31:0], lvl);
          n++;
          scan_level = lvl;
        end
      end
    end
    if (item.final_byte) begin
      // buffer ended before the start sample: start level reads as low
      if (active && !start_seen) begin
        batch[n]   = make_event(KIND_START, win_first, 1'b0);
        n++;
        scan_level = 1'b0;
        start_seen = 1'b1;
      end
      batch[n]    = make_event(KIND_DONE, '0, 1'b0);
      n++;
      scan_closed = 1'b1;
    end
    if (scan_pos != '1)
      scan_pos++;
    if (n > 0)
      batch[n-1].last_of_item = 1'b1;
    for (int k = 0; k < n; k++)
      expected_events = {expected_events, batch[k]};
  endfunction

  // Driver: inputs change on the falling edge; valid holds until the transfer.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      if (!in_valid || in_taken) begin
        if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          in_data  <= pending_bytes.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Monitor: predicts on each input transfer, checks each result transfer.
  always @(posedge clk) begin : monitor
    out_item_t want;
    if (!rst_n) begin
      in_taken = 1'b0;
    end else begin
      in_taken = in_valid && !in_stall;
      if (in_taken)
        extract_byte_events(in_data);
      if (out_valid && !out_stall) begin
        if (expected_events.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("%0t: unexpected result ch=%0d kind=%0d at=%0d lvl=%0d last=%0d", $time,
                     out_data.channel, out_data.kind, out_data.at_sample, out_data.level,
                     out_data.last_of_item);
        end else begin
          want = expected_events.pop_front();
          if (out_data.channel !== want.channel || out_data.kind !== want.kind ||
              out_data.at_sample !== want.at_sample || out_data.level !== want.level ||
              out_data.last_of_item !== want.last_of_item) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT) begin
              $write("%0t: mismatch want ch=%0d kind=%0d at=%0d lvl=%0d last=%0d,", $time,
                     want.channel, want.kind, want.at_sample, want.level,
                     want.last_of_item);
              $display(" got ch=%0d kind=%0d at=%0d lvl=%0d last=%0d", out_data.channel,
                       out_data.kind, out_data.at_sample, out_data.level,
                       out_data.last_of_item);
            end
          end
        end
      end
    end
  end

  // Watchdog: too long without any transfer or register write means a hang.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_CHANNEL_ID:   chan_label = val[3:0];
      REG_WINDOW_START: win_first  = val;
      REG_WINDOW_END:   win_limit  = val;
      REG_VALID_COUNT:  stored_len = val;
      default: ;
    endcase
  endtask

  task automatic set_window(input logic [3:0] chan, input logic [31:0] first,
                            input logic [31:0] stop, input logic [31:0] len);
    write_reg(REG_CHANNEL_ID, {28'd0, chan});
    write_reg(REG_WINDOW_START, first);
    write_reg(REG_WINDOW_END, stop);
    write_reg(REG_VALID_COUNT, len);
  endtask

  task automatic queue_byte(input logic [7:0] value, input logic fin);
    in_item_t item;
    item.sample_byte = value;
    item.final_byte  = fin;
    pending_bytes    = {pending_bytes, item};
  endtask

  task automatic set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_NONE:     begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SENDER:   begin sender_idle_pct = 69; recv_stall_pct = 0;  end
      IDLE_RECEIVER: begin sender_idle_pct = 0;  recv_stall_pct = 69; end
      default:       begin sender_idle_pct = 8;  recv_stall_pct = 8;  end
    endcase
  endtask

  // Waits until every byte has gone in and every result has come out, then
  // leaves room for a byte with no results still working through the core.
  task automatic settle();
    while (pending_bytes.size() != 0 || in_valid || expected_events.size() != 0)
      @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_sample_byte();
    logic [7:0] value;
    case ($urandom_range(0, 5))
      0:       value = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      1:       value = $urandom_range(0, 1) ? 8'hAA : 8'h55;
      2:       value = 8'h0F << $urandom_range(0, 4);
      default: value = 8'($urandom_range(0, 255));
    endcase
    return value;
  endfunction

  initial begin : stimulus
    logic [31:0] pos_bits, first_v, stop_v, len_v;
    int          random_sent, phase, span;
    random_sent = 0;
    phase       = 0;
    set_idling(IDLE_NONE);
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Reset window: start equals length (both zero), nothing is reported
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h00, 1'b0);
    settle();

    // Start level falls in the middle of the second byte after this write
    pos_bits = scan_pos << 3;
    set_window(4'hF, pos_bits + 11, 32'd0, 32'hFFFF_FFFF);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h08, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hAA, 1'b0);
    queue_byte(8'h55, 1'b0);
    queue_byte(8'h01, 1'b0);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'h0F, 1'b0);
    queue_byte(8'hF0, 1'b0);
    settle();

    // Window ends inside the next byte; the rest is padding
    pos_bits = scan_pos << 3;
    set_window(4'h0, win_first, pos_bits + 4, 32'hFFFF_FFFF);
    queue_byte(8'hAA, 1'b0);
    queue_byte(8'h55, 1'b0);
    settle();

    // End before start: no edges
    set_window(4'h7, win_first, 32'd5, 32'hFFFF_FFFF);
    queue_byte(8'hAA, 1'b0);
    settle();

    // Start at the length, all ones, then both zero: inactive
    set_window(4'h3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_byte(8'h55, 1'b0);
    settle();
    set_window(4'h3, 32'd0, 32'd5, 32'd0);
    queue_byte(8'hAA, 1'b0);
    settle();

    // End beyond the length is clipped to the length, mid-byte
    pos_bits = scan_pos << 3;
    set_window(4'hA, 32'd0, 32'hFFFF_FFF0, pos_bits + 6);
    queue_byte(8'h3C, 1'b0);
    queue_byte(8'hC3, 1'b0);
    settle();

    // Random phases, each with its own window and idling pattern
    while (random_sent < RANDOM_ITEMS) begin
      pos_bits = scan_pos << 3;
      case ($urandom_range(0, 15))
        0:       first_v = 32'hFFFF_FFFF;
        1:       first_v = $urandom;
        2, 3:    first_v = 32'd0;
        default: first_v = $urandom_range(0, pos_bits);
      endcase
      case ($urandom_range(0, 7))
        0:       len_v = 32'hFFFF_FFFF;
        1:       len_v = $urandom;
        default: len_v = pos_bits + $urandom_range(16, 600);
      endcase
      case ($urandom_range(0, 7))
        0:       stop_v = 32'd0;
        1:       stop_v = 32'hFFFF_FFFF;
        2:       stop_v = $urandom;
        3:       stop_v = pos_bits + $urandom_range(0, 40);
        4:       stop_v = $urandom_range(0, pos_bits);
        default: stop_v = pos_bits + $urandom_range(60, 400);
      endcase
      set_window(4'($urandom_range(0, 15)), first_v, stop_v, len_v);
      set_idling(idle_mode_t'(phase % 4));
      span = $urandom_range(12, 36);
      for (int k = 0; k < span; k++)
        queue_byte(pick_sample_byte(), 1'b0);
      random_sent += span;
      phase++;
      settle();
    end

    // Closing phase: the final byte ends the scan; later bytes are dropped
    pos_bits = scan_pos << 3;
    set_window(4'($urandom_range(0, 15)), $urandom_range(0, pos_bits), 32'd0,
               pos_bits + $urandom_range(1, 8));
    set_idling(IDLE_BOTH);
    queue_byte(pick_sample_byte(), 1'b0);
    queue_byte(pick_sample_byte(), 1'b1);
    for (int k = 0; k < 3; k++)
      queue_byte(pick_sample_byte(), 1'($urandom_range(0, 1)));
    settle();

    if (fail_count == 0 && expected_events.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
